/* rtl/ldmf_pkg.sv */
`default_nettype none

package ldmf_pkg;

    // default screen geometry
    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int DEF_PAGE_COUNT    = 8;

    // coordinate and error term widths of the line walker
    localparam int COORD_W = 8;
    localparam int ERR_W   = 10;

    // opcodes
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_PIX_RD  = 6'b000100,
        S_PIX_WR  = 6'b001000,
        S_BYTE_RD = 6'b010000,
        S_FINISH  = 6'b100000
    } t_state;

    // walker control: load endpoints, advance one pixel
    typedef struct packed {
        logic start;
        logic step;
    } t_walk_ctl;

    // walker status: current pixel, and whether it is the end point
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_walk_sts;

endpackage

`default_nettype wire

/* rtl/ldmf_ram.sv */
`default_nettype none

module ldmf_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/ldmf_walk.sv */
`default_nettype none

module ldmf_walk (
    input  wire logic                               i_clk,
    input  wire ldmf_pkg::t_walk_ctl                i_ctl,
    input  wire logic [ldmf_pkg::COORD_W-1:0]       i_x_start,
    input  wire logic [ldmf_pkg::COORD_W-1:0]       i_y_start,
    input  wire logic [ldmf_pkg::COORD_W-1:0]       i_x_end,
    input  wire logic [ldmf_pkg::COORD_W-1:0]       i_y_end,
    output ldmf_pkg::t_walk_sts                     o_sts
);

    import ldmf_pkg::*;

    logic [COORD_W-1:0]       r_x, r_y, r_x_end, r_y_end;
    logic [COORD_W-1:0]       r_dx, r_dy;
    logic                     r_sx, r_sy;
    logic signed [ERR_W-1:0]  r_err;

    logic [COORD_W-1:0]       w_dx0, w_dy0;
    logic signed [ERR_W-1:0]  w_err0;
    logic signed [ERR_W-1:0]  w_dx_s, w_dy_s;
    logic                     w_x_go, w_y_go;
    logic signed [ERR_W-1:0]  n_err;
    logic [COORD_W-1:0]       n_x, n_y;

    // setup terms from the endpoints
    always_comb begin
        w_dx0 = (i_x_end > i_x_start) ? (i_x_end - i_x_start) : (i_x_start - i_x_end);
        w_dy0 = (i_y_end > i_y_start) ? (i_y_end - i_y_start) : (i_y_start - i_y_end);
        // half of the major delta, negative when y dominates or the deltas tie
        if (w_dx0 > w_dy0) begin
            w_err0 = signed'(ERR_W'(w_dx0 >> 1));
        end else begin
            w_err0 = -signed'(ERR_W'(w_dy0 >> 1));
        end
    end

    // one bresenham step, both decisions from the old error
    always_comb begin
        w_dx_s = signed'(ERR_W'(r_dx));
        w_dy_s = signed'(ERR_W'(r_dy));
        w_x_go = r_err > -w_dx_s;
        w_y_go = r_err < w_dy_s;
        n_err  = r_err - (w_x_go ? w_dy_s : '0) + (w_y_go ? w_dx_s : '0);
        n_x    = r_x;
        n_y    = r_y;
        if (w_x_go) begin
            n_x = r_sx ? (r_x + 1'b1) : (r_x - 1'b1);
        end
        if (w_y_go) begin
            n_y = r_sy ? (r_y + 1'b1) : (r_y - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x     <= i_x_start;
            r_y     <= i_y_start;
            r_x_end <= i_x_end;
            r_y_end <= i_y_end;
            r_dx    <= w_dx0;
            r_dy    <= w_dy0;
            r_sx    <= i_x_start < i_x_end;
            r_sy    <= i_y_start < i_y_end;
            r_err   <= w_err0;
        end else if (i_ctl.step) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_err   <= n_err;
        end
    end

    assign o_sts.x    = r_x;
    assign o_sts.y    = r_y;
    assign o_sts.last = (r_x == r_x_end) && (r_y == r_y_end);

endmodule

`default_nettype wire

/* rtl/line_draw_mono_framebuffer_top.sv */
`default_nettype none

// channel  | dir | tdata (lsb first)                                  | tuser
// ---------+-----+----------------------------------------------------+-------
// s_axis   | in  | x_start 8, y_start 8, x_end 8, y_end 8, ink 1,     | opcode
//          |     | page_index 3, column_index 7, zero pad to 48 bits  |
// m_axis   | out | read_byte 8, rejected 1, zero pad to 16 bits       | none
//
// one word worked on at a time; a draw reads then writes the frame ram for each
// pixel; a byte read passes S_BYTE_RD then S_FINISH, a rejected draw goes
// straight to S_FINISH, and S_FINISH holds for any output stall
// after reset the ram is swept to zero, one byte a cycle, with tready low until
// all PAGE_COUNT * 2**clog2(SCREEN_WIDTH) bytes are cleared (1024 by default)
// a result waiting in the output register does not hold off the next word

module line_draw_mono_framebuffer_top #(
    parameter int SCREEN_WIDTH  = ldmf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ldmf_pkg::DEF_SCREEN_HEIGHT,
    parameter int PAGE_COUNT    = ldmf_pkg::DEF_PAGE_COUNT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x_start, y_start, x_end, y_end, ink, page_index, column_index
    input  wire logic [47:0] s_axis_tdata,
    // opcode
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_byte, rejected
    output logic [15:0]      m_axis_tdata
);

    import ldmf_pkg::*;

    // frame ram is addressed as {page, column}
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ADDR_W = PAGE_W + COL_W;
    localparam int DEPTH  = PAGE_COUNT * (2 ** COL_W);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // limits in widths that hold every field value and every limit
    localparam logic [8:0] WIDTH_LIM  = 9'(SCREEN_WIDTH);
    localparam logic [8:0] HEIGHT_LIM = 9'(SCREEN_HEIGHT);
    localparam logic [5:0] PAGE_LIM   = 6'(PAGE_COUNT);

    // input word fields
    logic       w_opcode;
    logic [7:0] w_x_start, w_y_start, w_x_end, w_y_end;
    logic       w_ink;
    logic [2:0] w_page_index;
    logic [6:0] w_column_index;
    logic       w_accept;

    assign w_opcode       = s_axis_tuser[0];
    assign w_x_start      = s_axis_tdata[7:0];
    assign w_y_start      = s_axis_tdata[15:8];
    assign w_x_end        = s_axis_tdata[23:16];
    assign w_y_end        = s_axis_tdata[31:24];
    assign w_ink          = s_axis_tdata[32];
    assign w_page_index   = s_axis_tdata[35:33];
    assign w_column_index = s_axis_tdata[42:36];

    // control and item registers
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic                r_ink, n_ink;
    logic                r_is_read, n_is_read;
    logic                r_rd_ok, n_rd_ok;
    logic [ADDR_W-1:0]   r_rd_addr, n_rd_addr;
    logic                r_rej, n_rej;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_byte, n_out_byte;
    logic                r_out_rej, n_out_rej;

    // walker
    t_walk_ctl           w_walk_ctl;
    t_walk_sts           w_walk_sts;

    // ram side
    logic                w_ram_we, w_ram_re;
    logic [ADDR_W-1:0]   w_ram_waddr, w_ram_raddr;
    logic [7:0]          w_ram_wdata, w_ram_rdata;

    // draw request checks
    logic                w_line_off;
    logic [5:0]          w_rd_page6;
    logic [8:0]          w_rd_col9;
    logic                w_rd_ok;
    logic [ADDR_W-1:0]   w_rd_addr;

    // current pixel
    logic [5:0]          w_pix_page6;
    logic [8:0]          w_pix_x9;
    logic                w_pix_ok;
    logic [ADDR_W-1:0]   w_pix_addr;
    logic [7:0]          w_pix_mask;
    logic [7:0]          w_pix_byte;
    logic                w_out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_line_off = ({1'b0, w_x_start} >= WIDTH_LIM)  || ({1'b0, w_x_end} >= WIDTH_LIM) ||
                        ({1'b0, w_y_start} >= HEIGHT_LIM) || ({1'b0, w_y_end} >= HEIGHT_LIM);

    assign w_rd_page6 = {3'b000, w_page_index};
    assign w_rd_col9  = {2'b00, w_column_index};
    assign w_rd_ok    = (w_rd_page6 < PAGE_LIM) && (w_rd_col9 < WIDTH_LIM);
    assign w_rd_addr  = {w_rd_page6[PAGE_W-1:0], w_rd_col9[COL_W-1:0]};

    // pixel (x, y) lives in bit y mod 8 of byte {y / 8, x}
    assign w_pix_page6 = {1'b0, w_walk_sts.y[7:3]};
    assign w_pix_x9    = {1'b0, w_walk_sts.x};
    assign w_pix_ok    = w_pix_page6 < PAGE_LIM;
    assign w_pix_addr  = {w_pix_page6[PAGE_W-1:0], w_pix_x9[COL_W-1:0]};
    assign w_pix_mask  = 8'b0000_0001 << w_walk_sts.y[2:0];
    assign w_pix_byte  = r_ink ? (w_ram_rdata | w_pix_mask) : (w_ram_rdata & ~w_pix_mask);

    assign w_out_free  = !r_out_valid || m_axis_tready;

    // walker is loaded on an accepted in-range draw, stepped after each write but the last
    assign w_walk_ctl.start = w_accept && (w_opcode == OP_DRAW) && !w_line_off;
    assign w_walk_ctl.step  = (r_state == S_PIX_WR) && !w_walk_sts.last;

    // ram access: the sweep and the pixel write share the write port;
    // a pixel read and its write sit in different cycles, so back-to-back
    // pixels in one byte always see the previous write
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = w_pix_addr;
        w_ram_wdata = w_pix_byte;
        w_ram_re    = 1'b0;
        w_ram_raddr = w_pix_addr;
        unique case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
            end
            S_PIX_RD: begin
                w_ram_re = w_pix_ok;
            end
            S_PIX_WR: begin
                w_ram_we = w_pix_ok;
            end
            S_BYTE_RD: begin
                w_ram_re    = r_rd_ok;
                w_ram_raddr = r_rd_addr;
            end
            S_IDLE, S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_ink       = r_ink;
        n_is_read   = r_is_read;
        n_rd_ok     = r_rd_ok;
        n_rd_addr   = r_rd_addr;
        n_rej       = r_rej;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_byte  = r_out_byte;
        n_out_rej   = r_out_rej;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_ink     = w_ink;
                    n_is_read = (w_opcode == OP_READ);
                    n_rd_ok   = w_rd_ok;
                    n_rd_addr = w_rd_addr;
                    n_rej     = 1'b0;
                    if (w_opcode == OP_READ) begin
                        n_state = S_BYTE_RD;
                    end else if (w_line_off) begin
                        // off-screen endpoint: nothing drawn
                        n_rej   = 1'b1;
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_PIX_RD;
                    end
                end
            end
            S_PIX_RD: begin
                n_state = S_PIX_WR;
            end
            S_PIX_WR: begin
                n_state = w_walk_sts.last ? S_FINISH : S_PIX_RD;
            end
            S_BYTE_RD: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = (r_is_read && r_rd_ok) ? w_ram_rdata : 8'h00;
                    n_out_rej   = r_rej;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_ink      <= n_ink;
        r_is_read  <= n_is_read;
        r_rd_ok    <= n_rd_ok;
        r_rd_addr  <= n_rd_addr;
        r_rej      <= n_rej;
        r_out_byte <= n_out_byte;
        r_out_rej  <= n_out_rej;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0000000, r_out_rej, r_out_byte};

    ldmf_walk u_walk (
        .i_clk     (i_clk),
        .i_ctl     (w_walk_ctl),
        .i_x_start (w_x_start),
        .i_y_start (w_y_start),
        .i_x_end   (w_x_end),
        .i_y_end   (w_y_end),
        .o_sts     (w_walk_sts)
    );

    ldmf_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule

`default_nettype wire

/* dv/line_draw_mono_framebuffer_top_tb.sv */
`default_nettype none

module line_draw_mono_framebuffer_top_tb;
    import ldmf_pkg::*;

    localparam int SCR_W = ldmf_pkg::DEF_SCREEN_WIDTH;
    localparam int SCR_H = ldmf_pkg::DEF_SCREEN_HEIGHT;
    localparam int PAGES = ldmf_pkg::DEF_PAGE_COUNT;

    // one result word as the block should return it
    typedef struct packed {
        logic [7:0] read_byte;
        logic       rejected;
    } t_fb_result;

    // mirror of the frame ram plus the queue of results still owed by the block
    class frame_scoreboard;
        bit [7:0]   pixel_bytes [0:PAGES-1][0:SCR_W-1];
        t_fb_result awaited_results [$];
        int         errors;
        int         results_checked;
        int         lines_drawn;
        int         lines_rejected;
        int         bytes_read;
        int         bytes_nonzero;

        function new();
            foreach (pixel_bytes[p, c]) pixel_bytes[p][c] = 8'h00;
            errors          = 0;
            results_checked = 0;
            lines_drawn     = 0;
            lines_rejected  = 0;
            bytes_read      = 0;
            bytes_nonzero   = 0;
        endfunction

        // accepted command word: update the mirror and queue the result it owes
        function void note_command(logic op, logic [47:0] data);
            t_fb_result res;
            int x, y, xe, ye, dx, dy, sx, sy, err, e2, guard;
            logic       ink;
            logic [2:0] page;
            logic [6:0] col;
            x    = data[7:0];
            y    = data[15:8];
            xe   = data[23:16];
            ye   = data[31:24];
            ink  = data[32];
            page = data[35:33];
            col  = data[42:36];
            res  = '0;
            if (op == OP_DRAW) begin
                if (x >= SCR_W || xe >= SCR_W || y >= SCR_H || ye >= SCR_H) begin
                    res.rejected = 1'b1;
                    lines_rejected++;
                end else begin
                    lines_drawn++;
                    dx  = (xe > x) ? xe - x : x - xe;
                    dy  = (ye > y) ? ye - y : y - ye;
                    sx  = (x < xe) ? 1 : -1;
                    sy  = (y < ye) ? 1 : -1;
                    // integer division truncates toward zero, as the walk needs
                    err = ((dx > dy) ? dx : -dy) / 2;
                    for (guard = 0; guard < 1024; guard++) begin
                        if ((y >> 3) < PAGES)
                            pixel_bytes[y >> 3][x][y & 7] = ink;
                        if (x == xe && y == ye)
                            break;
                        e2 = err;
                        if (e2 > -dx) begin
                            err -= dy;
                            x   += sx;
                        end
                        if (e2 < dy) begin
                            err += dx;
                            y   += sy;
                        end
                    end
                end
            end else begin
                bytes_read++;
                if (page < PAGES && col < SCR_W)
                    res.read_byte = pixel_bytes[page][col];
                if (res.read_byte != 8'h00)
                    bytes_nonzero++;
            end
            awaited_results.push_back(res);
        endfunction

        // accepted result word: compare against the oldest owed result
        function void check_result(logic [15:0] data);
            t_fb_result want;
            results_checked++;
            if (awaited_results.size() == 0) begin
                $error("result word %h arrived with nothing outstanding", data);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (data[7:0] !== want.read_byte) begin
                $error("read_byte: expected %02h, got %02h", want.read_byte, data[7:0]);
                errors++;
            end
            if (data[8] !== want.rejected) begin
                $error("rejected: expected %0b, got %0b", want.rejected, data[8]);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // x_start, y_start, x_end, y_end, ink, page_index, column_index
    logic [47:0] s_axis_tdata  = '0;
    // opcode
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // read_byte, rejected
    logic [15:0] m_axis_tdata;

    frame_scoreboard sb = new();

    // sender pacing
    int burst_left  = 0;
    int steady_left = 0;
    // last line start point, so reads tend to land on drawn pixels
    int last_x = 0;
    int last_y = 0;

    line_draw_mono_framebuffer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [47:0] pack_command(int xs, int ys, int xe, int ye, logic ink,
                                                 logic [2:0] page, logic [6:0] col);
        return {5'b0, col, page, ink, ye[7:0], xe[7:0], ys[7:0], xs[7:0]};
    endfunction

    // offer one word from a falling edge, return at the falling edge after acceptance
    task automatic drive_word(logic op, logic [47:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(op, data);
        @(negedge i_clk);
    endtask

    // bursts of random length with random gaps, and now and then a gapless stretch
    task automatic pace_sender();
        int gap;
        if (steady_left > 0) begin
            steady_left--;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0)
                steady_left = $urandom_range(15, 40);
        end
    endtask

    // draw with the unused read fields filled at random
    task automatic send_draw(int xs, int ys, int xe, int ye, logic ink);
        drive_word(OP_DRAW, pack_command(xs, ys, xe, ye, ink,
                                         3'($urandom), 7'($urandom)));
        if (xs < SCR_W && ys < SCR_H) begin
            last_x = xs;
            last_y = ys;
        end
        pace_sender();
    endtask

    // read with the unused line fields filled at random
    task automatic send_read(logic [2:0] page, logic [6:0] col);
        drive_word(OP_READ, pack_command($urandom_range(0, 255), $urandom_range(0, 255),
                                         $urandom_range(0, 255), $urandom_range(0, 255),
                                         1'($urandom), page, col));
        pace_sender();
    endtask

    function automatic int clamp(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    task automatic random_draw();
        int kind, xs, ys, xe, ye;
        logic ink;
        kind = $urandom_range(0, 99);
        ink  = ($urandom_range(0, 99) < 65);
        if (kind < 8) begin
            // one or more endpoints off screen
            xs = $urandom_range(0, 255);
            ys = $urandom_range(0, 255);
            xe = $urandom_range(0, 255);
            ye = $urandom_range(0, 255);
            case ($urandom_range(0, 3))
                0: xs = $urandom_range(SCR_W, 255);
                1: ys = $urandom_range(SCR_H, 255);
                2: xe = $urandom_range(SCR_W, 255);
                default: ye = $urandom_range(SCR_H, 255);
            endcase
        end else if (kind < 20) begin
            // anywhere on screen, up to full width
            xs = $urandom_range(0, SCR_W - 1);
            ys = $urandom_range(0, SCR_H - 1);
            xe = $urandom_range(0, SCR_W - 1);
            ye = $urandom_range(0, SCR_H - 1);
        end else begin
            // short segments keep the run fast and overlap often
            xs = $urandom_range(0, SCR_W - 1);
            ys = $urandom_range(0, SCR_H - 1);
            xe = clamp(xs + $urandom_range(0, 24) - 12, SCR_W - 1);
            ye = clamp(ys + $urandom_range(0, 24) - 12, SCR_H - 1);
        end
        send_draw(xs, ys, xe, ye, ink);
    endtask

    task automatic random_read();
        if ($urandom_range(0, 1))
            send_read(3'(last_y >> 3), 7'(last_x));
        else
            send_read(3'($urandom), 7'($urandom));
    endtask

    // receiver: sample at the rising edge, change tready at the falling edge
    initial begin : result_sink
        logic [15:0] rx_pattern;
        int          rx_phase;
        int          hold_left;
        bit          long_hold_done;
        rx_pattern     = 16'hffff;
        rx_phase       = 0;
        hold_left      = 0;
        long_hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            // one long hold-off once traffic is flowing, so the block backs up
            if (!long_hold_done && sb.results_checked >= 60) begin
                hold_left      = 400;
                long_hold_done = 1'b1;
            end
            @(negedge i_clk);
            if (rx_phase % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: rx_pattern = 16'hffff;
                    1: rx_pattern = 16'($urandom);
                    2: rx_pattern = 16'($urandom) & 16'($urandom);
                    default: rx_pattern = 16'($urandom) | 16'($urandom);
                endcase
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= rx_pattern[rx_phase % 16];
            end
            rx_phase++;
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int drain_cycles;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: cleared ram, extreme lines in several directions, off-screen rejects
        send_read(3'd0, 7'd0);
        send_draw(0, 0, SCR_W - 1, SCR_H - 1, 1'b1);
        send_read(3'd0, 7'd0);
        send_read(3'd7, 7'd127);
        send_draw(SCR_W - 1, 0, 0, 0, 1'b1);
        send_draw(0, SCR_H - 1, 0, 0, 1'b1);
        send_draw(5, 5, 5, 5, 1'b1);
        send_draw(10, 40, 13, 2, 1'b1);
        send_draw(100, 60, 20, 50, 1'b1);
        send_read(3'd0, 7'd64);
        send_read(3'd0, 7'd5);
        send_read(3'd5, 7'd12);
        send_draw(0, 0, SCR_W - 1, 0, 1'b0);
        send_read(3'd0, 7'd0);
        send_read(3'd0, 7'd127);
        send_draw(SCR_W, 0, 0, 0, 1'b1);
        send_draw(0, SCR_H, 0, 0, 1'b1);
        send_draw(0, 0, 255, 255, 1'b0);
        send_draw(255, 255, 255, 255, 1'b1);
        send_read(3'd0, 7'd0);
        send_draw(SCR_W - 1, SCR_H - 1, SCR_W - 1, SCR_H - 1, 1'b0);
        send_read(3'd7, 7'd127);
        send_read(3'd1, 7'd11);

        // random: mixed draws and read-backs
        repeat (450) begin
            if ($urandom_range(0, 99) < 55)
                random_draw();
            else
                random_read();
        end
        s_axis_tvalid <= 1'b0;

        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        // catch any stray result after the last one owed
        repeat (300) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end

        $display("run: %0d lines drawn, %0d off-screen lines flagged, %0d byte reads",
                 sb.lines_drawn, sb.lines_rejected, sb.bytes_read);
        $display("run: %0d reads returned set pixels, %0d result words checked",
                 sb.bytes_nonzero, sb.results_checked);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

/* line_draw_mono_framebuffer_top.f */
rtl/ldmf_pkg.sv
rtl/ldmf_ram.sv
rtl/ldmf_walk.sv
rtl/line_draw_mono_framebuffer_top.sv
dv/line_draw_mono_framebuffer_top_tb.sv
